// File: hw/rtl/edmc_pkg.sv
// Shared types and constants for the edge merger with self-loop histogram.
`timescale 1ns / 1ps

package edmc_pkg;

    localparam int FUNC_W = 2;
    localparam int VID_W  = 16;
    localparam int NUM_W  = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_EDGE  = 2'd0,
        FUNC_FLUSH = 2'd1,
        FUNC_QUERY = 2'd2
    } t_func;

    typedef enum logic {
        KIND_EDGE = 1'b0,
        KIND_LOOP = 1'b1
    } t_kind;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_store_ctl;

endpackage

// File: hw/rtl/edmc_if.sv
// Valid/ready channel interfaces for the input items and the result beats.
`timescale 1ns / 1ps

interface edmc_in_if;
    logic                         valid;
    logic                         ready;
    logic [edmc_pkg::FUNC_W-1:0]  func;
    logic [edmc_pkg::VID_W-1:0]   from_vertex;
    logic [edmc_pkg::VID_W-1:0]   to_vertex;
    logic [edmc_pkg::VID_W-1:0]   query_vertex;

    modport source (output valid, func, from_vertex, to_vertex, query_vertex, input ready);
    modport sink   (input valid, func, from_vertex, to_vertex, query_vertex, output ready);
endinterface

interface edmc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [edmc_pkg::VID_W-1:0]  edge_source;
    logic [edmc_pkg::VID_W-1:0]  edge_target;
    logic [edmc_pkg::NUM_W-1:0]  edge_number;
    logic [edmc_pkg::NUM_W-1:0]  multiplicity;
    logic [edmc_pkg::NUM_W-1:0]  loop_count;

    modport source (output valid, kind, edge_source, edge_target, edge_number, multiplicity,
                    loop_count, input ready);
    modport sink   (input valid, kind, edge_source, edge_target, edge_number, multiplicity,
                    loop_count, output ready);
endinterface

// File: hw/rtl/edge_dedup_with_multiplicity_core.sv
// A beat is registered in stage one, then its result in the o_out register; stage one
// holds on output stall. An edge result is offered once a new edge or a flush arrives.
// Throughput: one input beat per cycle unless output stall or clearing holds ready low,
// set by the read-modify-write of the self-loop memory (one read port, one write port,
// forwarding of the last write). Reset: control clears at once, then a clearing pass
// over all 2^VERTEX_BITS entries zeroes the self-loop memory; input ready stays low.
`timescale 1ns / 1ps

module edge_dedup_with_multiplicity_core #(
    parameter int VERTEX_BITS = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    edmc_in_if.sink       i_in,
    edmc_out_if.source    o_out
);

    localparam int FUNC_W = edmc_pkg::FUNC_W;
    localparam int VID_W  = edmc_pkg::VID_W;
    localparam int NUM_W  = edmc_pkg::NUM_W;

    logic                   r_s1_valid;
    logic [FUNC_W-1:0]      r_s1_func;
    logic [VERTEX_BITS-1:0] r_s1_src;
    logic [VERTEX_BITS-1:0] r_s1_dst;
    logic [VERTEX_BITS-1:0] r_s1_addr;

    logic                   r_out_valid;
    edmc_pkg::t_kind        r_out_kind;
    logic [VID_W-1:0]       r_out_src;
    logic [VID_W-1:0]       r_out_dst;
    logic [NUM_W-1:0]       r_out_num;
    logic [NUM_W-1:0]       r_out_mult;
    logic [NUM_W-1:0]       r_out_loop;

    logic                   w_accept;
    logic [VERTEX_BITS-1:0] w_in_src;
    logic [VERTEX_BITS-1:0] w_in_qv;
    logic [VERTEX_BITS-1:0] w_rd_addr;
    logic                   w_loop;
    logic                   w_query;
    logic                   w_emit;
    logic                   w_s1_result;
    logic                   w_out_free;
    logic                   w_s1_adv;
    logic                   w_busy;
    logic [COUNT_BITS-1:0]  w_rd_data;
    logic [COUNT_BITS-1:0]  w_wr_data;
    edmc_pkg::t_store_ctl   w_ctl;
    logic [VID_W-1:0]       w_m_src;
    logic [VID_W-1:0]       w_m_dst;
    logic [NUM_W-1:0]       w_m_num;
    logic [NUM_W-1:0]       w_m_mult;

    assign w_accept  = i_in.valid && i_in.ready;
    assign w_in_src  = VERTEX_BITS'(i_in.from_vertex);
    assign w_in_qv   = VERTEX_BITS'(i_in.query_vertex);
    assign w_rd_addr = (i_in.func == edmc_pkg::FUNC_QUERY) ? w_in_qv : w_in_src;

    assign w_loop      = (r_s1_func == edmc_pkg::FUNC_EDGE) && (r_s1_src == r_s1_dst);
    assign w_query     = (r_s1_func == edmc_pkg::FUNC_QUERY);
    assign w_s1_result = r_s1_valid && (w_query || w_emit);
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_s1_adv    = r_s1_valid && (!w_s1_result || w_out_free);

    assign i_in.ready = !w_busy && (!r_s1_valid || w_s1_adv);

    assign w_ctl.rd_en = w_accept;
    assign w_ctl.wr_en = w_s1_adv && (w_loop || w_query);
    assign w_wr_data   = w_query ? '0
                       : (w_rd_data == {COUNT_BITS{1'b1}}) ? w_rd_data
                       : w_rd_data + COUNT_BITS'(1);

    edmc_store #(
        .VERTEX_BITS (VERTEX_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data),
        .o_busy    (w_busy)
    );

    edmc_merge #(
        .VERTEX_BITS (VERTEX_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_s1_adv),
        .i_func  (r_s1_func),
        .i_src   (r_s1_src),
        .i_dst   (r_s1_dst),
        .o_emit  (w_emit),
        .o_src   (w_m_src),
        .o_dst   (w_m_dst),
        .o_num   (w_m_num),
        .o_mult  (w_m_mult)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_func <= i_in.func;
            r_s1_src  <= w_in_src;
            r_s1_dst  <= VERTEX_BITS'(i_in.to_vertex);
            r_s1_addr <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv && w_s1_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && w_s1_result) begin
            if (w_query) begin
                r_out_kind <= edmc_pkg::KIND_LOOP;
                r_out_src  <= '0;
                r_out_dst  <= '0;
                r_out_num  <= '0;
                r_out_mult <= '0;
                r_out_loop <= NUM_W'(w_rd_data);
            end else begin
                r_out_kind <= edmc_pkg::KIND_EDGE;
                r_out_src  <= w_m_src;
                r_out_dst  <= w_m_dst;
                r_out_num  <= w_m_num;
                r_out_mult <= w_m_mult;
                r_out_loop <= '0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out_kind;
    assign o_out.edge_source  = r_out_src;
    assign o_out.edge_target  = r_out_dst;
    assign o_out.edge_number  = r_out_num;
    assign o_out.multiplicity = r_out_mult;
    assign o_out.loop_count   = r_out_loop;

`ifndef ASSERT_OFF
    a_s1_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_result && !w_out_free |=> r_s1_valid && $stable(r_s1_addr) && $stable(r_s1_func))
        else $error("stage one dropped a beat under output stall");

    a_empty_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !r_s1_valid && !r_out_valid)
        else $error("beat in flight during clearing pass");

    a_query_gives_loop_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv && w_query |=> r_out_valid && r_out_kind == edmc_pkg::KIND_LOOP)
        else $error("query did not produce a loop count beat");
`endif

endmodule

// File: hw/rtl/edmc_store.sv
// Self-loop count memory with clearing pass after reset and read-after-write forwarding.
`timescale 1ns / 1ps

module edmc_store #(
    parameter int VERTEX_BITS = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  edmc_pkg::t_store_ctl     i_ctl,
    input  logic [VERTEX_BITS-1:0]   i_rd_addr,
    input  logic [VERTEX_BITS-1:0]   i_wr_addr,
    input  logic [COUNT_BITS-1:0]    i_wr_data,
    output logic [COUNT_BITS-1:0]    o_rd_data,
    output logic                     o_busy
);

    localparam int DEPTH = 1 << VERTEX_BITS;

    logic [COUNT_BITS-1:0]  r_mem [DEPTH];
    logic [COUNT_BITS-1:0]  r_rdata;
    logic [COUNT_BITS-1:0]  r_fwd_data;
    logic                   r_fwd_hit;
    logic                   r_busy;
    logic [VERTEX_BITS-1:0] r_clr_addr;

    logic                   w_wr_en;
    logic [VERTEX_BITS-1:0] w_wr_addr;
    logic [COUNT_BITS-1:0]  w_wr_data;

    assign w_wr_en   = r_busy || i_ctl.wr_en;
    assign w_wr_addr = r_busy ? r_clr_addr : i_wr_addr;
    assign w_wr_data = r_busy ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata    <= r_mem[i_rd_addr];
            r_fwd_hit  <= i_ctl.wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    // sweep every entry to zero once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + VERTEX_BITS'(1);
            if (r_clr_addr == {VERTEX_BITS{1'b1}}) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rdata;
    assign o_busy    = r_busy;

`ifndef ASSERT_OFF
    a_no_wr_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr_en |-> !r_busy)
        else $error("store written during clearing pass");

    a_no_rd_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.rd_en |-> !r_busy)
        else $error("store read during clearing pass");

    a_clear_covers_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_clr_addr) == {VERTEX_BITS{1'b1}})
        else $error("clearing pass ended early");
`endif

endmodule

// File: hw/rtl/edmc_merge.sv
// Pending edge tracker: merges runs of equal edges and numbers unique edges.
`timescale 1ns / 1ps

module edmc_merge #(
    parameter int VERTEX_BITS = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [edmc_pkg::FUNC_W-1:0]  i_func,
    input  logic [VERTEX_BITS-1:0]       i_src,
    input  logic [VERTEX_BITS-1:0]       i_dst,
    output logic                         o_emit,
    output logic [edmc_pkg::VID_W-1:0]   o_src,
    output logic [edmc_pkg::VID_W-1:0]   o_dst,
    output logic [edmc_pkg::NUM_W-1:0]   o_num,
    output logic [edmc_pkg::NUM_W-1:0]   o_mult
);

    localparam int VID_W = edmc_pkg::VID_W;
    localparam int NUM_W = edmc_pkg::NUM_W;

    logic                   r_pend_valid;
    logic [VERTEX_BITS-1:0] r_pend_src;
    logic [VERTEX_BITS-1:0] r_pend_dst;
    logic [COUNT_BITS-1:0]  r_run;
    logic [NUM_W-1:0]       r_num;

    logic w_is_edge;
    logic w_loop;
    logic w_same;
    logic w_new;
    logic w_flush;

    assign w_is_edge = (i_func == edmc_pkg::FUNC_EDGE);
    assign w_loop    = w_is_edge && (i_src == i_dst);
    assign w_same    = w_is_edge && !w_loop && r_pend_valid
                       && (i_src == r_pend_src) && (i_dst == r_pend_dst);
    assign w_new     = w_is_edge && !w_loop && !w_same;
    assign w_flush   = (i_func == edmc_pkg::FUNC_FLUSH);

    assign o_emit = r_pend_valid && (w_new || w_flush);
    assign o_src  = VID_W'(r_pend_src);
    assign o_dst  = VID_W'(r_pend_dst);
    assign o_num  = r_num;
    assign o_mult = NUM_W'(r_run);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_run        <= '0;
            r_num        <= '0;
        end else if (i_step) begin
            priority if (w_new) begin
                r_pend_valid <= 1'b1;
                r_pend_src   <= i_src;
                r_pend_dst   <= i_dst;
                r_run        <= COUNT_BITS'(1);
                if (r_pend_valid) begin
                    r_num <= r_num + NUM_W'(1);
                end
            end else if (w_same) begin
                r_run <= (r_run == {COUNT_BITS{1'b1}}) ? r_run : r_run + COUNT_BITS'(1);
            end else if (w_flush) begin
                r_pend_valid <= 1'b0;
                r_run        <= '0;
                r_num        <= '0;
            end else begin
                r_pend_valid <= r_pend_valid;
            end
        end
    end

`ifndef ASSERT_OFF
    a_pending_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_run != '0)
        else $error("pending edge with zero multiplicity");

    a_flush_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_flush |=> !r_pend_valid && r_num == '0)
        else $error("flush did not restart numbering");

    a_new_run_starts_at_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_new |=> r_pend_valid && r_run == COUNT_BITS'(1))
        else $error("new run did not start at one");
`endif

endmodule
